// ===== hdl/glyph_atlas_slot_cache_top_macros.svh =====
// assertion macros used by the checker file
`ifndef GLYPH_ATLAS_SLOT_CACHE_TOP_MACROS_SVH
`define GLYPH_ATLAS_SLOT_CACHE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GACS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GACS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gacs_pkg.sv =====
package gacs_pkg;

    // configuration limits
    localparam int MAX_CELLS_PER_ROW = 32;
    localparam int TEXTURE_SIZE      = 1024;

    // field widths
    localparam int CODE_W  = 16;
    localparam int SIZE_W  = 11;
    localparam int CPR_W   = 6;
    localparam int CFG_W   = 11;
    localparam int CELL_W  = 10;
    localparam int COORD_W = 10;
    localparam int SIZE_MAX = 1024;

    // grid geometry derived from the limits
    localparam int GRID_W     = $clog2(MAX_CELLS_PER_ROW);
    localparam int N_W        = GRID_W + 1;
    localparam int SLOT_W     = 2 * GRID_W;
    localparam int SLOT_COUNT = MAX_CELLS_PER_ROW * MAX_CELLS_PER_ROW;
    localparam int CODE_COUNT = 1 << CODE_W;

    // table entry layouts: valid bit on top
    localparam int C2C_W = SLOT_W + 1;
    localparam int CTC_W = CODE_W + 1;

    // register indexes
    localparam logic [0:0] REG_CELL_SIZE     = 1'b0;
    localparam logic [0:0] REG_CELLS_PER_ROW = 1'b1;

    // row and column of a cell; packed form equals row * MAX + col
    typedef struct packed {
        logic [GRID_W-1:0] row;
        logic [GRID_W-1:0] col;
    } cell_pos_t;

    // what the geometry unit reports for a cell
    typedef struct packed {
        logic [CELL_W-1:0]  index;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } cell_geom_t;

endpackage

// ===== hdl/gacs_ram.sv =====
module gacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/gacs_alloc.sv =====
module gacs_alloc (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic [gacs_pkg::N_W-1:0]  n,
    output gacs_pkg::cell_pos_t       next_pos
);
    import gacs_pkg::*;

    logic [GRID_W-1:0] row_reg;
    logic [GRID_W-1:0] col_reg;
    logic [N_W-1:0]    col_inc;
    logic [N_W-1:0]    row_inc;

    // round-robin step in row-major order, wrap outside the grid
    always_comb
    begin
        col_inc = {1'b0, col_reg} + N_W'(1);
        row_inc = {1'b0, row_reg};
        if (col_inc >= n)
        begin
            col_inc = '0;
            row_inc = {1'b0, row_reg} + N_W'(1);
        end
        if (row_inc >= n)
        begin
            row_inc = '0;
            col_inc = '0;
        end
        next_pos.row = row_inc[GRID_W-1:0];
        next_pos.col = col_inc[GRID_W-1:0];
    end

    // pointer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (adv)
        begin
            row_reg <= next_pos.row;
            col_reg <= next_pos.col;
        end
    end

endmodule

// ===== hdl/gacs_geom.sv =====
module gacs_geom (
    input  gacs_pkg::cell_pos_t          pos,
    input  logic [gacs_pkg::N_W-1:0]     n,
    input  logic [gacs_pkg::SIZE_W-1:0]  size,
    output gacs_pkg::cell_geom_t         geom
);
    import gacs_pkg::*;

    localparam int PROD_W = GRID_W + SIZE_W;
    localparam int IDX_W  = GRID_W + N_W + 1;

    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [IDX_W-1:0]  idx_sum;

    // texel coordinates, saturated at the texture edge
    assign prod_x = PROD_W'(pos.col) * PROD_W'(size);
    assign prod_y = PROD_W'(pos.row) * PROD_W'(size);

    // linear index with the current row length
    assign idx_sum = IDX_W'(pos.row) * IDX_W'(n) + IDX_W'(pos.col);

    always_comb
    begin
        geom.index = idx_sum[CELL_W-1:0];
        if (prod_x > PROD_W'(TEXTURE_SIZE - 1))
        begin
            geom.x = COORD_W'(TEXTURE_SIZE - 1);
        end
        else
        begin
            geom.x = prod_x[COORD_W-1:0];
        end
        if (prod_y > PROD_W'(TEXTURE_SIZE - 1))
        begin
            geom.y = COORD_W'(TEXTURE_SIZE - 1);
        end
        else
        begin
            geom.y = prod_y[COORD_W-1:0];
        end
    end

endmodule

// ===== hdl/glyph_atlas_slot_cache_top.sv =====
// Glyph atlas slot cache: maps 16-bit character codes to cells of a square
// atlas grid with round-robin replacement. Each transfer on the input gives
// one result: the cell (index, texel x and y), a hit flag and the code that a
// miss evicted. A hit or a miss into a free cell ends in the lookup state, a
// miss that evicts adds an eviction state: the code-to-cell memory is read,
// then written back, plus one more write to invalidate the evicted code. The
// block works on one item at a time and takes the next while the previous
// result waits on the output. After reset both tables are swept clear, one
// entry per cycle, while no input is taken (configuration writes still are).
// Write configuration only while no item is in flight.
module glyph_atlas_slot_cache_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [gacs_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gacs_pkg::CODE_W-1:0]   char_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [gacs_pkg::CELL_W-1:0]   cell_index,
    output logic [gacs_pkg::COORD_W-1:0]  cell_x,
    output logic [gacs_pkg::COORD_W-1:0]  cell_y,
    output logic                          evicted_valid,
    output logic [gacs_pkg::CODE_W-1:0]   evicted_code
);
    import gacs_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_EVICT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CODE_W-1:0]  clr_cnt_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [SIZE_W-1:0]  cell_size_reg;
    logic [CPR_W-1:0]   cells_per_row_reg;

    logic               out_valid_reg;
    logic               hit_reg;
    logic [CELL_W-1:0]  cell_index_reg;
    logic [COORD_W-1:0] cell_x_reg;
    logic [COORD_W-1:0] cell_y_reg;
    logic               ev_valid_reg;
    logic [CODE_W-1:0]  ev_code_reg;

    logic [N_W-1:0]     n_eff;
    logic [SIZE_W-1:0]  size_eff;
    logic               accept;
    logic               out_free;
    logic               finish_look;
    logic               adv;
    logic               c2c_hit;
    logic               held_valid;

    cell_pos_t          alloc_pos;
    cell_pos_t          geom_pos;
    cell_geom_t         geom;

    logic               c2c_we;
    logic [CODE_W-1:0]  c2c_waddr;
    logic [C2C_W-1:0]   c2c_wdata;
    logic [C2C_W-1:0]   c2c_rdata;
    logic               ctc_we;
    logic [SLOT_W-1:0]  ctc_waddr;
    logic [CTC_W-1:0]   ctc_wdata;
    logic [CTC_W-1:0]   ctc_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg     <= SIZE_W'(65);
            cells_per_row_reg <= CPR_W'(15);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_SIZE:     cell_size_reg     <= cfg_data[SIZE_W-1:0];
                REG_CELLS_PER_ROW: cells_per_row_reg <= cfg_data[CPR_W-1:0];
                default:           ;
            endcase
        end
    end

    // clamp registers to their usable range
    always_comb
    begin
        if (cells_per_row_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (int'(cells_per_row_reg) > MAX_CELLS_PER_ROW)
        begin
            n_eff = N_W'(MAX_CELLS_PER_ROW);
        end
        else
        begin
            n_eff = N_W'(cells_per_row_reg);
        end
        if (cell_size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (int'(cell_size_reg) > SIZE_MAX)
        begin
            size_eff = SIZE_W'(SIZE_MAX);
        end
        else
        begin
            size_eff = cell_size_reg;
        end
    end

    // handshake
    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign c2c_hit     = c2c_rdata[SLOT_W];
    assign held_valid  = ctc_rdata[CODE_W];
    assign finish_look = (state_reg == S_LOOK) && out_free;
    assign adv         = finish_look && !c2c_hit;

    // allocation pointer
    gacs_alloc u_alloc (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .n        (n_eff),
        .next_pos (alloc_pos)
    );

    // cell of the result: bound cell on a hit, next pointer cell on a miss
    assign geom_pos = c2c_hit ? cell_pos_t'(c2c_rdata[SLOT_W-1:0]) : alloc_pos;

    gacs_geom u_geom (
        .pos  (geom_pos),
        .n    (n_eff),
        .size (size_eff),
        .geom (geom)
    );

    // table write ports: clearing sweep, binding, eviction
    always_comb
    begin
        c2c_we    = 1'b0;
        c2c_waddr = code_reg;
        c2c_wdata = '0;
        ctc_we    = 1'b0;
        ctc_waddr = alloc_pos;
        ctc_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                c2c_we    = 1'b1;
                c2c_waddr = clr_cnt_reg;
                ctc_we    = 1'b1;
                ctc_waddr = clr_cnt_reg[SLOT_W-1:0];
            end
            S_LOOK:
            begin
                c2c_we    = adv;
                c2c_wdata = {1'b1, SLOT_W'(alloc_pos)};
                ctc_we    = adv;
                ctc_wdata = {1'b1, code_reg};
            end
            S_EVICT:
            begin
                c2c_we    = 1'b1;
                c2c_waddr = ev_code_reg;
            end
            default:
            begin
                c2c_we = 1'b0;
            end
        endcase
    end

    // code-to-cell table
    gacs_ram #(
        .WIDTH (C2C_W),
        .DEPTH (CODE_COUNT)
    ) u_c2c_ram (
        .clk     (clk),
        .wr_en   (c2c_we),
        .wr_addr (c2c_waddr),
        .wr_data (c2c_wdata),
        .rd_en   (accept),
        .rd_addr (char_code),
        .rd_data (c2c_rdata)
    );

    // cell-to-code table, read at the cell a miss would take
    gacs_ram #(
        .WIDTH (CTC_W),
        .DEPTH (SLOT_COUNT)
    ) u_ctc_ram (
        .clk     (clk),
        .wr_en   (ctc_we),
        .wr_addr (ctc_waddr),
        .wr_data (ctc_wdata),
        .rd_en   (accept),
        .rd_addr (SLOT_W'(alloc_pos)),
        .rd_data (ctc_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    if (!c2c_hit && held_valid)
                    begin
                        state_next = S_EVICT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EVICT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CODE_W'(1);
            end
        end
    end

    // requested code
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= char_code;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_look)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_look)
        begin
            hit_reg        <= c2c_hit;
            cell_index_reg <= geom.index;
            cell_x_reg     <= geom.x;
            cell_y_reg     <= geom.y;
            ev_valid_reg   <= !c2c_hit && held_valid;
            ev_code_reg    <= (!c2c_hit && held_valid) ? ctc_rdata[CODE_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign cell_index    = cell_index_reg;
    assign cell_x        = cell_x_reg;
    assign cell_y        = cell_y_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_code  = ev_code_reg;

endmodule

// ===== hdl/gacs_checker.sv =====
`include "glyph_atlas_slot_cache_top_macros.svh"

module gacs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          hit,
    input logic                          evicted_valid,
    input logic [gacs_pkg::CODE_W-1:0]   evicted_code
);

    // a result waiting on a stalled output stays offered
    `GACS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

    // a hit never reports an eviction
    `GACS_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !evicted_valid, "eviction on a hit")

    // no eviction means a zero code
    `GACS_ASSERT_NOW(a_evict_code_zero, out_valid && !evicted_valid, evicted_code == '0,
        "evicted code without eviction")

    // one item at a time: the cycle after a transfer in, input is stalled
    `GACS_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second item taken early")

endmodule

bind glyph_atlas_slot_cache_top gacs_checker u_gacs_checker (.*);

// ===== tb/glyph_atlas_slot_cache_top_test.sv =====
`timescale 1ns / 1ps

module glyph_atlas_slot_cache_top_test;
    import gacs_pkg::*;

    localparam int unsigned PHASE_ITEMS      = 210;
    localparam int unsigned RANDOM_PHASES    = 9;
    localparam int unsigned LONG_HOLD_AT     = 300;
    localparam int unsigned LONG_HOLD_CYCLES = 90;
    localparam int unsigned SETTLE_CYCLES    = 6;

    // one result as the block reports it
    typedef struct {
        logic               hit;
        logic [CELL_W-1:0]  index;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               ev_valid;
        logic [CODE_W-1:0]  ev_code;
    } glyph_slot_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [0:0]           cfg_index = REG_CELL_SIZE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CODE_W-1:0]    char_code = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 hit;
    logic [CELL_W-1:0]    cell_index;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic                 evicted_valid;
    logic [CODE_W-1:0]    evicted_code;

    // shadow of the cache state and registers
    logic [C2C_W-1:0]     code_cell [CODE_COUNT];
    logic [CTC_W-1:0]     cell_code [SLOT_COUNT];
    int unsigned          ptr_row;
    int unsigned          ptr_col;
    logic [SIZE_W-1:0]    cfg_cell_size;
    logic [CPR_W-1:0]     cfg_row_cells;

    logic [CODE_W-1:0]    pending_codes [$];
    logic [CODE_W-1:0]    recent_codes [$];
    glyph_slot_t          expected_slots [$];

    bit                   send_idle_on = 1'b1;
    bit                   recv_idle_on = 1'b1;
    int unsigned          send_gap = 0;
    int unsigned          recv_wait = 0;
    int unsigned          recv_next;
    int unsigned          results_seen = 0;
    int unsigned          fail_count = 0;

    glyph_atlas_slot_cache_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .cell_index    (cell_index),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .evicted_valid (evicted_valid),
        .evicted_code  (evicted_code)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned idle_draw(input bit enabled);
        return enabled ? $urandom_range(0, 8) : 0;
    endfunction

    // texel coordinate of a grid line, saturated to the texture edge
    function automatic logic [COORD_W-1:0] texel_of(input int unsigned k,
                                                    input int unsigned sz);
        int unsigned v;
        v = k * sz;
        if (v > TEXTURE_SIZE - 1)
            v = TEXTURE_SIZE - 1;
        return COORD_W'(v);
    endfunction

    // look up one code, update the shadow tables, return the cell it lands in
    function automatic glyph_slot_t lookup_glyph(input logic [CODE_W-1:0] code);
        glyph_slot_t        r;
        int unsigned        n;
        int unsigned        sz;
        int unsigned        row;
        int unsigned        col;
        int unsigned        slot;
        logic [C2C_W-1:0]   entry;
        logic [CTC_W-1:0]   held;

        n  = (cfg_row_cells == 0) ? 1 : cfg_row_cells;
        if (n > MAX_CELLS_PER_ROW)
            n = MAX_CELLS_PER_ROW;
        sz = (cfg_cell_size == 0) ? 1 : cfg_cell_size;
        if (sz > SIZE_MAX)
            sz = SIZE_MAX;

        r.hit      = 1'b0;
        r.ev_valid = 1'b0;
        r.ev_code  = '0;
        entry      = code_cell[code];

        if (entry[C2C_W-1])
        begin
            // bound earlier: report its row and column under the current grid
            slot  = entry[SLOT_W-1:0];
            r.hit = 1'b1;
            row   = slot / MAX_CELLS_PER_ROW;
            col   = slot % MAX_CELLS_PER_ROW;
        end
        else
        begin
            // advance the round-robin pointer, wrapping to cell 0 off the grid
            col = ptr_col + 1;
            row = ptr_row;
            if (col >= n)
            begin
                col = 0;
                row = row + 1;
            end
            if (row >= n)
            begin
                row = 0;
                col = 0;
            end
            ptr_col = col;
            ptr_row = row;

            // evict the previous tenant and bind the new code
            slot = row * MAX_CELLS_PER_ROW + col;
            held = cell_code[slot];
            if (held[CTC_W-1])
            begin
                r.ev_valid = 1'b1;
                r.ev_code  = held[CODE_W-1:0];
                code_cell[held[CODE_W-1:0]] = '0;
            end
            cell_code[slot] = {1'b1, code};
            code_cell[code] = {1'b1, SLOT_W'(slot)};
        end

        r.index = CELL_W'(row * n + col);
        r.x     = texel_of(col, sz);
        r.y     = texel_of(row, sz);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    // request side: offer queued codes, predict each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            char_code <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_slots.insert(expected_slots.size(), lookup_glyph(char_code));
            if (!(in_valid && in_stall))
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_codes.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    char_code <= pending_codes.pop_front();
                    send_gap  <= idle_draw(send_idle_on);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side: random stall per transfer, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_slots.size() == 0)
                begin
                    $display("%0t ns: result with none expected, expected none, got cell %0d",
                             $time, cell_index);
                    fail_count++;
                end
                else
                begin
                    glyph_slot_t want;
                    want = expected_slots.pop_front();
                    check_field("hit", want.hit, hit);
                    check_field("cell_index", want.index, cell_index);
                    check_field("cell_x", want.x, cell_x);
                    check_field("cell_y", want.y, cell_y);
                    check_field("evicted_valid", want.ev_valid, evicted_valid);
                    check_field("evicted_code", want.ev_code, evicted_code);
                end
                results_seen++;
                recv_next = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
                                                           : idle_draw(recv_idle_on);
            end
            else
            begin
                recv_next = (recv_wait > 0) ? recv_wait - 1 : 0;
            end
            recv_wait <= recv_next;
            out_stall <= (recv_next != 0);
        end
    end

    task automatic queue_code(input logic [CODE_W-1:0] code);
        pending_codes.insert(pending_codes.size(), code);
        recent_codes.insert(recent_codes.size(), code);
        if (recent_codes.size() > 64)
            void'(recent_codes.pop_front());
    endtask

    // hold back until every transfer has its result and the block is quiet
    task automatic drain();
        @(negedge clk);
        while (pending_codes.size() != 0 || in_valid || expected_slots.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CELL_SIZE)
            cfg_cell_size = val[SIZE_W-1:0];
        else
            cfg_row_cells = val[CPR_W-1:0];
    endtask

    // stimulus sequence
    initial
    begin
        logic [CODE_W-1:0] pool [$];
        logic [CFG_W-1:0]  sz_val;
        logic [CFG_W-1:0]  rc_val;
        int unsigned       pool_n;

        for (int i = 0; i < CODE_COUNT; i++)
            code_cell[i] = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
            cell_code[i] = '0;
        ptr_row       = 0;
        ptr_col       = 0;
        cfg_cell_size = SIZE_W'(65);
        cfg_row_cells = CPR_W'(15);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: field extremes, first allocation at cell 1, a hit
        queue_code(16'h0000);
        queue_code(16'hFFFF);
        queue_code(16'h0000);
        queue_code(16'hAAAA);
        queue_code(16'h5555);
        queue_code(16'hFFFF);
        drain();

        // one-cell grid with zero size: pointer wraps, every later miss evicts,
        // old bindings keep their row and column
        write_reg(REG_CELLS_PER_ROW, 11'd1);
        write_reg(REG_CELL_SIZE, 11'd0);
        queue_code(16'h1234);
        queue_code(16'h1234);
        queue_code(16'h4321);
        queue_code(16'h1234);
        queue_code(16'h0000);
        queue_code(16'hFFFF);
        drain();

        // zero grid with junk high bits, oversized cell: coordinates saturate
        write_reg(REG_CELLS_PER_ROW, 11'h7C0);
        write_reg(REG_CELL_SIZE, 11'h7FF);
        queue_code(16'hAAAA);
        queue_code(16'hBEEF);
        queue_code(16'h5555);
        drain();

        // oversized grid clamps to the maximum
        write_reg(REG_CELLS_PER_ROW, 11'd63);
        write_reg(REG_CELL_SIZE, 11'd1024);
        queue_code(16'h0101);
        queue_code(16'h8000);
        queue_code(16'h7FFF);
        drain();

        // random phases over a working set of codes per geometry
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: begin sz_val = 11'd1;    rc_val = 11'd32; end
                1: begin sz_val = 11'd1024; rc_val = 11'd32; end
                2: begin sz_val = 11'd33;   rc_val = 11'd2;  end
                3: begin sz_val = 11'd0;    rc_val = 11'd3;  end
                4: begin sz_val = 11'd2047; rc_val = 11'd1;  end
                default:
                begin
                    sz_val = CFG_W'($urandom_range(0, 2047));
                    rc_val = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 2047))
                                                         : CFG_W'($urandom_range(1, 6));
                end
            endcase
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(REG_CELL_SIZE, sz_val);
                write_reg(REG_CELLS_PER_ROW, rc_val);
            end
            else
            begin
                write_reg(REG_CELLS_PER_ROW, rc_val);
                write_reg(REG_CELL_SIZE, sz_val);
            end
            send_idle_on = (p % 3 != 1);
            recv_idle_on = (p % 4 != 2);

            // mix fresh codes with ones bound under earlier geometries
            pool.delete();
            pool_n = $urandom_range(3, 40);
            for (int i = 0; i < pool_n; i++)
            begin
                if (recent_codes.size() != 0 && $urandom_range(0, 2) == 0)
                    pool.insert(pool.size(),
                                recent_codes[$urandom_range(0, recent_codes.size() - 1)]);
                else
                    pool.insert(pool.size(), CODE_W'($urandom_range(0, 65535)));
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 3) != 0)
                    queue_code(pool[$urandom_range(0, pool_n - 1)]);
                else
                    queue_code(CODE_W'($urandom_range(0, 65535)));
            end
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/gacs_pkg.sv
hdl/gacs_ram.sv
hdl/gacs_alloc.sv
hdl/gacs_geom.sv
hdl/glyph_atlas_slot_cache_top.sv
hdl/gacs_checker.sv
tb/glyph_atlas_slot_cache_top_test.sv
